// ----- rtl/vks_pkg.sv -----
// Shared types, constants and helper functions of the vehicle kinematic step block.
`default_nettype none

package vks_pkg;

  localparam int CMD_W       = 16;
  localparam int POS_W       = 32;
  localparam int SPD_W       = 32;
  localparam int ANG_W       = 16;
  localparam int TRIG_W      = 16;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam int MUL_AW      = 49;
  localparam int MUL_BW      = 17;
  localparam int MUL_PW      = MUL_AW + MUL_BW;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_ITER  = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int CORDIC_CW    = $clog2(CORDIC_ITER);
  localparam int ATAN_IW      = $clog2(ATAN_ENTRIES);
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] REG_ROTATION_RATE = 2'd0;
  localparam logic [1:0] REG_SPEED_FACTOR  = 2'd1;
  localparam logic [1:0] REG_MAX_SPEED     = 2'd2;
  localparam logic [1:0] REG_MIN_SPEED     = 2'd3;

  localparam logic [15:0] ROTATION_RATE_RST = 16'd4096;
  localparam logic [15:0] SPEED_FACTOR_RST  = 16'd256;
  localparam logic signed [SPD_W-1:0] MAX_SPEED_RST = 32'sd1048576;
  localparam logic signed [SPD_W-1:0] MIN_SPEED_RST = 32'sd0;

  typedef struct packed {
    logic [15:0]              rotation_rate;
    logic [15:0]              speed_factor;
    logic signed [SPD_W-1:0]  max_speed;
    logic signed [SPD_W-1:0]  min_speed;
  } vks_cfg_t;

  typedef struct packed {
    logic                     valid;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } vks_trig_t;

  function automatic logic signed [CORDIC_W-1:0] cordic_atan(input logic [ATAN_IW-1:0] idx);
    logic signed [CORDIC_W-1:0] v;
    unique case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [SPD_W-1:0] sat32(input logic signed [SPD_W:0] v);
    logic signed [SPD_W-1:0] r;
    if (v[SPD_W] != v[SPD_W-1]) begin
      r = v[SPD_W] ? {1'b1, {(SPD_W-1){1'b0}}} : {1'b0, {(SPD_W-1){1'b1}}};
    end else begin
      r = v[SPD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/vks_if.sv -----
// Input and result channel interfaces of the vehicle kinematic step block.
`default_nettype none

interface vks_in_if import vks_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  steer;
  logic [CMD_W-1:0]  throttle;
  logic [CMD_W-1:0]  brake_cmd;
  logic [CMD_W-1:0]  elapsed;

  modport source (output valid, output steer, output throttle, output brake_cmd,
                  output elapsed, input ready);
  modport sink   (input valid, input steer, input throttle, input brake_cmd,
                  input elapsed, output ready);
endinterface

interface vks_out_if import vks_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [ANG_W-1:0]         heading;
  logic signed [TRIG_W-1:0] heading_cos;
  logic signed [TRIG_W-1:0] heading_sin;
  logic signed [SPD_W-1:0]  speed_out;

  modport source (output valid, output pos_x, output pos_y, output heading,
                  output heading_cos, output heading_sin, output speed_out, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading,
                  input heading_cos, input heading_sin, input speed_out, output ready);
endinterface

`default_nettype wire

// ----- rtl/vehicle_kinematic_step.sv -----
// Top level of the vehicle kinematic step block: sequencer, state and result register.
// Usage:
//   Each word on in_ch is one simulation tick: steer, throttle, brake_cmd and elapsed,
//   all Q0.16. Each accepted word yields exactly one word on out_ch: the new centre
//   (pos_x, pos_y, Q16.16), heading as a binary angle, its Q1.15 cosine and sine, and
//   the scaled speed after decay.
//   The configuration registers (rotation_rate, speed_factor, max_speed, min_speed)
//   sit at byte addresses 0, 4, 8 and 12 of the APB port; write them only while idle.
// Timing:
//   in_ch.ready is high only while the sequencer is idle. After acceptance the sequencer
//   steps through throttle, brake, heading update and clamp, CORDIC start, the distance
//   and decay products, then waits for the CORDIC iterations plus a rounding step and a
//   handover step, then runs two passes for the position deltas, the write-back and the
//   output load that raises out_ch.valid. The next word is taken in the cycle after the
//   result is loaded, not before; most of the time is spent in the CORDIC loop.
// Reset:
//   rst_n (synchronous, active low) clears heading, speed and centre to zero and loads
//   the register defaults.
// Back-pressure:
//   A finished result waits in the output register while the next item is taken and
//   worked on; that item then holds in its last step until out_ch.ready frees the slot.
`default_nettype none

module vehicle_kinematic_step import vks_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  vks_in_if.sink            in_ch,
  vks_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_H1   = 4'd1;
  localparam logic [3:0] S_H2   = 4'd2;
  localparam logic [3:0] S_HD   = 4'd3;
  localparam logic [3:0] S_CS   = 4'd4;
  localparam logic [3:0] S_VW   = 4'd5;
  localparam logic [3:0] S_DK   = 4'd6;
  localparam logic [3:0] S_CW   = 4'd7;
  localparam logic [3:0] S_PX   = 4'd8;
  localparam logic [3:0] S_PY   = 4'd9;
  localparam logic [3:0] S_FIN  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  vks_cfg_t                 cfg;
  vks_trig_t                trig;
  logic [3:0]               state_r;
  logic [CMD_W-1:0]         steer_r, thr_r, brk_r, dt_r;
  logic [ANG_W-1:0]         heading_r;
  logic signed [SPD_W-1:0]  scaled_speed_r, spd_r;
  logic [POS_W-1:0]         centre_x_r, centre_y_r;
  logic signed [47:0]       pv_r;
  logic [23:0]              decay_r;
  logic                     out_valid_r;
  logic signed [POS_W-1:0]  pos_x_r, pos_y_r, speed_out_r;
  logic [ANG_W-1:0]         heading_out_r;
  logic signed [TRIG_W-1:0] cos_out_r, sin_out_r;

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod_r;
  logic signed [MUL_PW-1:0] rnd_sum;
  logic [17:0]              steer_term;
  logic                     cordic_start;
  logic                     out_load;

  vks_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vks_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  vks_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (heading_r),
    .res   (trig)
  );

  assign steer_term   = {1'b0, steer_r, 1'b0} - 18'h10000;
  assign rnd_sum      = prod_r + 66'sh4000_0000;
  assign cordic_start = (state_r == S_CS);
  assign out_load     = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_H1: begin
        mul_a = MUL_AW'($signed(steer_term[16:0]));
        mul_b = MUL_BW'(cfg.rotation_rate);
      end
      S_H2: begin
        mul_a = MUL_AW'($signed(prod_r[32:0]));
        mul_b = MUL_BW'(dt_r);
      end
      S_CS: begin
        mul_a = MUL_AW'(spd_r);
        mul_b = MUL_BW'(dt_r);
      end
      S_VW: begin
        mul_a = MUL_AW'(dt_r);
        mul_b = MUL_BW'(cfg.speed_factor);
      end
      S_PX: begin
        mul_a = MUL_AW'(pv_r);
        mul_b = MUL_BW'(trig.cos_v);
      end
      S_PY: begin
        mul_a = MUL_AW'(pv_r);
        mul_b = MUL_BW'(trig.sin_v);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      heading_r      <= '0;
      scaled_speed_r <= '0;
      centre_x_r     <= '0;
      centre_y_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            steer_r <= in_ch.steer;
            thr_r   <= in_ch.throttle;
            brk_r   <= in_ch.brake_cmd;
            dt_r    <= in_ch.elapsed;
            state_r <= S_H1;
          end
        end
        S_H1: begin
          spd_r   <= sat32({scaled_speed_r[SPD_W-1], scaled_speed_r} + {17'b0, thr_r});
          state_r <= S_H2;
        end
        S_H2: begin
          spd_r   <= sat32({spd_r[SPD_W-1], spd_r} - {17'b0, brk_r});
          state_r <= S_HD;
        end
        S_HD: begin
          heading_r <= heading_r + prod_r[47:32];
          if (spd_r > cfg.max_speed) begin
            spd_r <= cfg.max_speed;
          end else if (spd_r < cfg.min_speed) begin
            spd_r <= cfg.min_speed;
          end
          state_r <= S_CS;
        end
        S_CS: state_r <= S_VW;
        S_VW: begin
          pv_r    <= prod_r[47:0];
          state_r <= S_DK;
        end
        S_DK: begin
          decay_r <= prod_r[31:8];
          state_r <= S_CW;
        end
        S_CW: begin
          if (trig.valid) begin
            state_r <= S_PX;
          end
        end
        S_PX: state_r <= S_PY;
        S_PY: begin
          centre_x_r <= centre_x_r + rnd_sum[62:31];
          state_r    <= S_FIN;
        end
        S_FIN: begin
          centre_y_r     <= centre_y_r + rnd_sum[62:31];
          scaled_speed_r <= sat32({spd_r[SPD_W-1], spd_r} - {9'b0, decay_r});
          state_r        <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x_r       <= centre_x_r;
      pos_y_r       <= centre_y_r;
      heading_out_r <= heading_r;
      cos_out_r     <= trig.cos_v;
      sin_out_r     <= trig.sin_v;
      speed_out_r   <= scaled_speed_r;
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.pos_x       = pos_x_r;
  assign out_ch.pos_y       = pos_y_r;
  assign out_ch.heading     = heading_out_r;
  assign out_ch.heading_cos = cos_out_r;
  assign out_ch.heading_sin = sin_out_r;
  assign out_ch.speed_out   = speed_out_r;

endmodule

`default_nettype wire

// ----- rtl/vks_cfg.sv -----
// APB configuration register file of the vehicle kinematic step block.
`default_nettype none

module vks_cfg import vks_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output vks_cfg_t          cfg
);

  vks_cfg_t   cfg_r;
  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation_rate <= ROTATION_RATE_RST;
      cfg_r.speed_factor  <= SPEED_FACTOR_RST;
      cfg_r.max_speed     <= MAX_SPEED_RST;
      cfg_r.min_speed     <= MIN_SPEED_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_ROTATION_RATE: cfg_r.rotation_rate <= pwdata[15:0];
        REG_SPEED_FACTOR:  cfg_r.speed_factor  <= pwdata[15:0];
        REG_MAX_SPEED:     cfg_r.max_speed     <= $signed(pwdata);
        REG_MIN_SPEED:     cfg_r.min_speed     <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROTATION_RATE: prdata = {16'b0, cfg_r.rotation_rate};
      REG_SPEED_FACTOR:  prdata = {16'b0, cfg_r.speed_factor};
      REG_MAX_SPEED:     prdata = cfg_r.max_speed;
      REG_MIN_SPEED:     prdata = cfg_r.min_speed;
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/vks_mul.sv -----
// Shared registered signed multiplier of the vehicle kinematic step block.
`default_nettype none

module vks_mul import vks_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_AW-1:0] op_a,
  input  logic signed [MUL_BW-1:0] op_b,
  output logic signed [MUL_PW-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

`default_nettype wire

// ----- rtl/vks_cordic.sv -----
// Iterative rotation-mode CORDIC giving the Q1.15 cosine and sine of a heading.
`default_nettype none

module vks_cordic import vks_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ANG_W-1:0] angle,
  output vks_trig_t        res
);

  logic signed [CORDIC_W-1:0] x_r, y_r, z_r;
  logic [CORDIC_CW-1:0]       cnt_r;
  logic                       busy_r, fin_r, flip_r;
  vks_trig_t                  res_r;
  logic                       flip;
  logic signed [CORDIC_W-1:0] z0, xs, ys, atan_v, xf, yf;

  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] r;
    logic signed [TRIG_W-1:0]   q;
    r = (v + 34'sd16384) >>> 15;
    if (r > 34'sd32767) begin
      q = 16'sh7fff;
    end else if (r < -34'sd32768) begin
      q = 16'sh8000;
    end else begin
      q = r[TRIG_W-1:0];
    end
    return q;
  endfunction

  assign flip   = (angle > 16'h4000) && (angle < 16'hC000);
  assign z0     = CORDIC_W'($signed({angle ^ {flip, 15'b0}, 16'b0}));
  assign xs     = x_r >>> cnt_r;
  assign ys     = y_r >>> cnt_r;
  assign atan_v = cordic_atan(ATAN_IW'(cnt_r));
  assign xf     = flip_r ? -x_r : x_r;
  assign yf     = flip_r ? -y_r : y_r;
  assign res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      fin_r     <= 1'b0;
      res_r.valid <= 1'b0;
    end else if (start) begin
      x_r       <= CORDIC_GAIN;
      y_r       <= '0;
      z_r       <= z0;
      flip_r    <= flip;
      cnt_r     <= '0;
      busy_r    <= 1'b1;
      fin_r     <= 1'b0;
      res_r.valid <= 1'b0;
    end else if (busy_r) begin
      if (!z_r[CORDIC_W-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_v;
      end
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CORDIC_CW'(CORDIC_ITER - 1)) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end else if (fin_r) begin
      res_r.cos_v <= to_q15(xf);
      res_r.sin_v <= to_q15(yf);
      res_r.valid <= 1'b1;
      fin_r       <= 1'b0;
    end
  end

endmodule

`default_nettype wire
